// File: design/assert_macros.svh
// assertion macros used by the checker file bsd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is held
`define BSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsd check failed");

// next-cycle implication, masked while reset is held
`define BSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsd check failed");

// next-cycle implication that also holds through reset
`define BSD_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bsd reset check failed");

`endif

// File: design/bsd_pkg.sv
// types, constants and helper functions of the backslash escape decoder
package bsd_pkg;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESC    = 3'd1,
    PH_OCT    = 3'd2,
    PH_HEX    = 3'd3,
    PH_UNI    = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] acc;
    logic [3:0]  cnt;
    logic        wide;
    logic [7:0]  letter;
    logic [7:0]  first;
  } esc_t;

  localparam esc_t ESC_IDLE = '{PH_NORMAL, 32'd0, 4'd0, 1'b0, 8'd0, 8'd0};

  localparam int unsigned MAX_BYTES = 5;

  // bytes produced by one input transaction, first byte in slot 0
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
  } burst_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hexd_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      cnt;
  } utf8_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ESCAPE = 8'h1B;

  function automatic hexd_t hex_dec(input logic [7:0] c);
    hexd_t r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r.ok  = 1'b1;
      r.val = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      r.ok  = 1'b1;
      r.val = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      r.ok  = 1'b1;
      r.val = 4'(c - "A" + 8'd10);
    end
    return r;
  endfunction

  // utf-8 encoding; surrogates and values past the unicode range give no bytes
  function automatic utf8_t utf8_enc(input logic [31:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 32'h80) begin
      r.b[0] = cp[7:0];
      r.cnt  = 3'd1;
    end else if (cp < 32'h800) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.cnt  = 3'd2;
    end else if (cp < 32'h10000) begin
      if (!(cp >= 32'hD800 && cp <= 32'hDFFF)) begin
        r.b[0] = {4'b1110, cp[15:12]};
        r.b[1] = {2'b10, cp[11:6]};
        r.b[2] = {2'b10, cp[5:0]};
        r.cnt  = 3'd3;
      end
    end else if (cp <= 32'h10FFFF) begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.cnt  = 3'd4;
    end
    return r;
  endfunction

endpackage

// File: design/bsd_decode.sv
// escape state register and the per-byte decode logic
module bsd_decode import bsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output burst_t     res
);

  esc_t  esc_r, esc_nxt;
  esc_t  st;
  logic  plain;
  hexd_t hv;
  hexd_t hv_first;
  logic  uni_done;
  logic  is_oct;
  logic [31:0] uni_cp;
  utf8_t u8;

  assign hv       = hex_dec(in_byte);
  assign hv_first = hex_dec(esc_r.first);
  assign is_oct   = (in_byte[7:3] == 5'b00110);
  assign uni_done = (4'(esc_r.cnt + 4'd1) >= (esc_r.wide ? 4'd8 : 4'd4));
  assign uni_cp   = hv.ok ? {esc_r.acc[27:0], hv.val} : esc_r.acc;
  assign u8       = utf8_enc(uni_cp);

  // next state
  always_comb begin
    st    = esc_r;
    plain = 1'b0;
    unique case (esc_r.phase)
      PH_ESC: begin
        st = ESC_IDLE;
        case (in_byte) inside
          "0", "1", "2", "3", "4", "5", "6", "7": begin
            st.acc   = {29'd0, in_byte[2:0]};
            st.cnt   = 4'd1;
            st.phase = PH_OCT;
          end
          "x", "X": begin
            st.letter = in_byte;
            st.phase  = PH_HEX;
          end
          "u", "U": begin
            st.wide  = (in_byte == "U");
            st.phase = PH_UNI;
          end
          default: ;
        endcase
      end
      PH_OCT: begin
        if (is_oct && esc_r.cnt < 4'd2) begin
          st.acc = {23'd0, esc_r.acc[5:0], in_byte[2:0]};
          st.cnt = 4'(esc_r.cnt + 4'd1);
        end else begin
          st    = ESC_IDLE;
          plain = !is_oct;
        end
      end
      PH_HEX: begin
        if (hv.ok && esc_r.cnt == 4'd0) begin
          st.first = in_byte;
          st.cnt   = 4'd1;
        end else begin
          st    = ESC_IDLE;
          plain = !hv.ok;
        end
      end
      PH_UNI: begin
        if (hv.ok && !uni_done) begin
          st.acc = uni_cp;
          st.cnt = 4'(esc_r.cnt + 4'd1);
        end else begin
          st    = ESC_IDLE;
          plain = !hv.ok;
        end
      end
      default: begin
        st    = ESC_IDLE;
        plain = 1'b1;
      end
    endcase

    esc_nxt = st;
    if (plain && in_byte == CH_BSLASH)
      esc_nxt.phase = PH_ESC;
    if (in_last)
      esc_nxt = ESC_IDLE;
  end

  // output bytes
  always_comb begin
    logic [MAX_BYTES-1:0][7:0] ob;
    logic [2:0]                n;
    ob = '0;
    n  = 3'd0;
    unique case (esc_r.phase)
      PH_ESC: begin
        case (in_byte) inside
          "a":                          begin ob[n] = 8'h07; n = n + 3'd1; end
          "b":                          begin ob[n] = 8'h08; n = n + 3'd1; end
          "e", "E":                     begin ob[n] = CH_ESCAPE; n = n + 3'd1; end
          "f":                          begin ob[n] = 8'h0C; n = n + 3'd1; end
          "n":                          begin ob[n] = 8'h0A; n = n + 3'd1; end
          "r":                          begin ob[n] = 8'h0D; n = n + 3'd1; end
          "t":                          begin ob[n] = 8'h09; n = n + 3'd1; end
          "v":                          begin ob[n] = 8'h0B; n = n + 3'd1; end
          CH_BSLASH, "'", "\"", "?":    begin ob[n] = in_byte; n = n + 3'd1; end
          "0", "1", "2", "3", "4", "5", "6", "7", "x", "X", "u", "U": ;
          default: begin
            ob[n] = CH_BSLASH;
            n     = n + 3'd1;
            ob[n] = in_byte;
            n     = n + 3'd1;
          end
        endcase
      end
      PH_OCT: begin
        if (!is_oct) begin
          ob[n] = esc_r.acc[7:0];
          n     = n + 3'd1;
        end else if (esc_r.cnt >= 4'd2) begin
          ob[n] = {esc_r.acc[4:0], in_byte[2:0]};
          n     = n + 3'd1;
        end
      end
      PH_HEX: begin
        if (hv.ok) begin
          if (esc_r.cnt != 4'd0) begin
            ob[n] = {hv_first.val, hv.val};
            n     = n + 3'd1;
          end
        end else begin
          ob[n] = CH_BSLASH;
          n     = n + 3'd1;
          ob[n] = esc_r.letter;
          n     = n + 3'd1;
          if (esc_r.cnt != 4'd0) begin
            ob[n] = esc_r.first;
            n     = n + 3'd1;
          end
        end
      end
      PH_UNI: begin
        if ((hv.ok && uni_done) || (!hv.ok && esc_r.cnt != 4'd0)) begin
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < u8.cnt) begin
              ob[n] = u8.b[i];
              n     = n + 3'd1;
            end
          end
        end
      end
      default: ;
    endcase

    if (plain) begin
      if (in_byte != CH_BSLASH || in_last) begin
        ob[n] = in_byte;
        n     = n + 3'd1;
      end
    end

    // flush of an escape left open by the final byte
    if (in_last) begin
      unique case (st.phase)
        PH_ESC: begin
          ob[n] = CH_BSLASH;
          n     = n + 3'd1;
        end
        PH_OCT: begin
          ob[n] = st.acc[7:0];
          n     = n + 3'd1;
        end
        PH_HEX: begin
          ob[n] = CH_BSLASH;
          n     = n + 3'd1;
          ob[n] = st.letter;
          n     = n + 3'd1;
          if (st.cnt != 4'd0) begin
            ob[n] = st.first;
            n     = n + 3'd1;
          end
        end
        PH_UNI: begin
          if (st.cnt != 4'd0) begin
            for (int i = 0; i < 4; i++) begin
              if (3'(i) < u8.cnt) begin
                ob[n] = u8.b[i];
                n     = n + 3'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    res.bytes = ob;
    res.cnt   = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= ESC_IDLE;
    end else if (in_fire) begin
      esc_r <= esc_nxt;
    end
  end

endmodule

// File: design/bsd_outbuf.sv
// result register that holds one burst and hands it out a byte per cycle while out_tready is high
module bsd_outbuf import bsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  burst_t     res,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [MAX_BYTES-1:0][7:0] data_r, data_nxt;
  logic [2:0]                cnt_r, cnt_nxt;
  logic                      pop;

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = data_r[0];
  assign out_tlast  = (cnt_r == 3'd1);
  assign pop        = out_tvalid && out_tready;
  // free when empty or when the last byte leaves in this cycle
  assign in_tready  = (cnt_r == 3'd0) || (out_tlast && out_tready);

  always_comb begin
    data_nxt = data_r;
    cnt_nxt  = cnt_r;
    if (in_fire && res.cnt != 3'd0) begin
      data_nxt = res.bytes;
      cnt_nxt  = res.cnt;
    end else if (pop) begin
      data_nxt = data_r >> 8;
      cnt_nxt  = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// File: design/backslash_escape_decoder.sv
// top level of the backslash escape decoder with utf-8 output
//
//  channel | direction | tdata          | tlast            | tuser
//  in_     | slave     | [7:0] raw byte | final byte       | -
//  out_    | master    | [7:0] decoded  | last of its burst| -
//
// a byte is decoded in the cycle it is accepted; its 0 to 5 result bytes land
// in the result register and appear on out_ in the next cycle, one per cycle while
// out_tready is high; an input transaction holds the result register until its
// last byte leaves, and the next byte is taken in the cycle that byte leaves, so plain
// text runs at one byte per cycle with no gaps while out_tready is high
// in_tready follows out_tready combinationally through the result register state
// synchronous active-low reset returns the escape state to normal text and empties
// the result register
module backslash_escape_decoder import bsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // text_end
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // run_last
);

  logic   in_fire;
  burst_t res;

  // input transaction completes
  assign in_fire = in_tvalid && in_tready;

  // escape state machine and byte decode
  bsd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .res     (res)
  );

  // result register and serialiser
  bsd_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .res        (res),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: design/bsd_checker.sv
// port-level checks of the backslash escape decoder and their bind
`include "assert_macros.svh"

module bsd_port_checks (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a waiting result stays offered
  `BSD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  // a waiting result keeps its payload
  `BSD_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable({out_tdata, out_tlast}))
  // while the result register holds bytes, input is only taken as its last byte leaves
  `BSD_ASSERT_NOW(a_in_when_free, in_tready && out_tvalid, out_tready && out_tlast)
  // an empty result register always raises in_tready
  `BSD_ASSERT_NOW(a_empty_ready, !out_tvalid, in_tready)
  // nothing is offered right after reset
  `BSD_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid)

endmodule

bind backslash_escape_decoder bsd_port_checks u_bsd_port_checks (.*);
